### sv/lru_key_value_cache_assert.svh
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LKVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// next-cycle implication, checked outside reset
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

### sv/lkvc_pkg.sv
// shared constants for the lru key-value cache
package lkvc_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 16;
    localparam int VALUE_W       = 32;
    localparam int CAP_W         = 5;
    localparam int IN_TDATA_W    = KEY_W + VALUE_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage

### sv/lkvc_ram.sv
// generic single-port-write ram with registered read
module lkvc_ram #(
    parameter int WIDTH = lkvc_pkg::VALUE_W,
    parameter int DEPTH = lkvc_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

### sv/lru_key_value_cache.sv
// an accepted transaction moves from the input register to the output register
// throughput: one transaction per cycle unless the output stalls; key match and rank
// update are combinational; the value store ram's registered read feeds the result stage
// reset clears valid bits, recency ranks and the entry count; capacity returns to 16
// key and value contents are not reset
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
    parameter int DEPTH = lkvc_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata,   // capacity
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]   s_tdata,     // key, value
    input  logic                              s_tuser,     // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lkvc_pkg::VALUE_W-1:0]      m_tdata,     // read_value
    output logic                              m_tuser      // hit
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
    localparam int KW = lkvc_pkg::KEY_W;
    localparam int VW = lkvc_pkg::VALUE_W;

    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

    logic          in_valid_reg;
    logic          in_op_reg;
    logic [KW-1:0] in_key_reg;
    logic [VW-1:0] in_value_reg;

    logic          out_valid_reg;
    logic          out_hit_reg;
    logic          out_rd_reg;

    logic [KW-1:0] key_reg   [DEPTH];
    logic [IW-1:0] rank_reg  [DEPTH];
    logic [IW-1:0] rank_next [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic             advance;
    logic             commit;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] oldest;
    logic [IW-1:0]    hit_idx;
    logic [IW-1:0]    victim_idx;
    logic [IW-1:0]    tgt_idx;
    logic [IW-1:0]    last_rank;
    logic [IW-1:0]    old_rank;
    logic [EW-1:0]    cap_ext;
    logic [EW-1:0]    cap_eff;
    logic             hit;
    logic             is_put;
    logic             fill;
    logic             was_valid;
    logic             ram_we;
    logic             ram_re;
    logic [VW-1:0]    ram_rdata;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign commit   = in_valid_reg && advance;
    assign is_put   = (in_op_reg == lkvc_pkg::OP_PUT);

    // effective capacity, zero taken as one and saturated at depth
    always_comb
    begin
        cap_ext = EW'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_eff = EW'(1);
        end
        else if (cap_ext > EW'(DEPTH))
        begin
            cap_eff = EW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // valid ranks are a permutation of 0 .. count-1, so the oldest holds count-1
    assign last_rank = IW'(count_reg - CW'(1));

    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == in_key_reg);
            oldest[i] = valid_reg[i] && (rank_reg[i] == last_rank);
            if (match[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
            if (oldest[i])
            begin
                victim_idx = victim_idx | IW'(i);
            end
        end
    end

    assign hit       = |match;
    assign fill      = !hit && is_put && (EW'(count_reg) < cap_eff);
    assign was_valid = !fill;
    // entries are never dropped, so the first free slot sits at the count
    assign tgt_idx   = hit ? hit_idx : (fill ? IW'(count_reg) : victim_idx);
    assign old_rank  = rank_reg[tgt_idx];

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (commit && (hit || is_put))
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (IW'(i) == tgt_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (!was_valid || rank_reg[i] < old_rank))
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            if (fill)
            begin
                valid_next[tgt_idx] = 1'b1;
                count_next          = count_reg + CW'(1);
            end
        end
    end

    assign ram_we = commit && is_put;
    assign ram_re = commit && !is_put && hit;

    lkvc_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx),
        .wdata (in_value_reg),
        .re    (ram_re),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= lkvc_pkg::CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tuser;
            in_key_reg   <= s_tdata[KW-1:0];
            in_value_reg <= s_tdata[KW+VW-1:KW];
        end
        if (commit)
        begin
            out_hit_reg <= hit;
            out_rd_reg  <= hit && !is_put;
        end
        if (commit && is_put && !hit)
        begin
            key_reg[tgt_idx] <= in_key_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_rd_reg ? ram_rdata : '0;

    `LKVC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `LKVC_ASSERT_NOW(a_valid_count, clk, rst_n, 1'b1, $countones(valid_reg) == int'(count_reg))
    `LKVC_ASSERT_NOW(a_match_unique, clk, rst_n, in_valid_reg, $onehot0(match))
    `LKVC_ASSERT_NEXT(a_fill_count, clk, rst_n, commit && fill,
        count_reg == $past(count_reg) + CW'(1))
    `LKVC_ASSERT_NEXT(a_commit_result, clk, rst_n, commit, m_tvalid)

endmodule
